// ----- src/kwm_pkg.sv -----
// Shared types and constants for the k-way sorted merge core.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  // Fixed field widths
  localparam int KIND_W    = 2;
  localparam int LIDX_W    = 3;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 4;
  localparam int IN_DATA_W = 40;   // list_index + value, padded to bytes
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start_pop;   // pop transaction accepted: reset the search
    logic do_append;   // append transaction accepted
    logic do_clear;    // clear transaction accepted
    logic issue;       // read the head of the list under the scan index
    logic finish;      // write the result and advance the winning list
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_lt_n;   // scan index still below the active list count
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// ----- src/kwm_ctrl.sv -----
// Controller state machine for the k-way sorted merge core.
// Depends on kwm_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module kwm_ctrl
  import kwm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic [KIND_W-1:0] in_kind,
  output logic                   in_tready,
  input  wire sts_t              sts,
  output cmd_t                   cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_tvalid && (state_r == S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (kind_t'(in_kind) == KIND_POP)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_lt_n) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.start_pop = accept && (kind_t'(in_kind) == KIND_POP);
        cmd.do_append = accept && (kind_t'(in_kind) == KIND_APPEND);
        cmd.do_clear  = accept && (kind_t'(in_kind) == KIND_CLEAR);
      end
      S_SCAN: begin
        cmd.issue = sts.scan_lt_n;
      end
      S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/kwm_datapath.sv -----
// Datapath of the k-way sorted merge core: element memory, per-list length
// and read pointers, head scan and compare, output register. Depends on kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_datapath
  import kwm_pkg::*;
#(
  parameter int LIST_COUNT = 8,
  parameter int LIST_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [LIDX_W-1:0]     in_list_index,
  input  wire logic [VAL_W-1:0]      in_value,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VAL_W-1:0]           out_merged_value,
  output logic                       out_empty_res,
  output logic                       out_last
);

  localparam int LW    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int CW    = $clog2(LIST_COUNT + 1);
  localparam int PW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LENW  = $clog2(LIST_DEPTH + 1);
  localparam int AW    = LW + PW;
  localparam int MEM_D = LIST_COUNT << PW;

  // Configuration register
  logic [CFG_W-1:0] cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Active list count, saturated to LIST_COUNT
  logic [CW-1:0] n_act;
  assign n_act = (int'(cfg_r) > LIST_COUNT) ? CW'(LIST_COUNT) : CW'(cfg_r);

  // Scan index
  logic [CW-1:0] idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.start_pop) begin
      idx_r <= '0;
    end else if (cmd.issue) begin
      idx_r <= idx_r + CW'(1);
    end
  end
  assign sts.scan_lt_n = (idx_r < n_act);

  // Per-list length and read pointer, one read index shared by append and scan
  logic [LENW-1:0] len_r [LIST_COUNT];
  logic [LENW-1:0] pos_r [LIST_COUNT];
  logic [LW-1:0]   app_idx, rd_idx, best_idx_r;
  logic [LENW-1:0] rd_len, rd_pos, best_pos_r;
  logic            app_ok;
  logic            found_r;   // some list in use had a head this scan

  assign app_idx = LW'(in_list_index);
  assign rd_idx  = cmd.issue ? idx_r[LW-1:0] : app_idx;
  assign rd_len  = len_r[rd_idx];
  assign rd_pos  = pos_r[rd_idx];
  assign app_ok  = (int'(in_list_index) < LIST_COUNT) && (rd_len < LENW'(LIST_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LIST_COUNT; i++) begin
        len_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else if (cmd.do_clear) begin
      for (int i = 0; i < LIST_COUNT; i++) begin
        len_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      if (cmd.do_append && app_ok) begin
        len_r[app_idx] <= rd_len + LENW'(1);
      end
      if (cmd.finish && found_r) begin
        pos_r[best_idx_r] <= best_pos_r + LENW'(1);
      end
    end
  end

  // Element memory: one write port (append), one registered read port (scan)
  logic [VAL_W-1:0] mem [MEM_D];
  logic [VAL_W-1:0] rdata_r;
  logic [AW-1:0]    mem_addr;

  assign mem_addr = {rd_idx, rd_pos[PW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.do_append && app_ok) begin
      mem[{app_idx, rd_len[PW-1:0]}] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[mem_addr];
  end

  // Head read stage: list state alongside the memory read
  logic            s1_valid_r;
  logic [LW-1:0]   s1_idx_r;
  logic [LENW-1:0] s1_pos_r;
  logic            s1_more1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue && (rd_pos < rd_len);
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= rd_idx;
    s1_pos_r   <= rd_pos;
    s1_more1_r <= ({1'b0, rd_pos} + (LENW+1)'(1)) < {1'b0, rd_len};
  end

  // Compare stage: keep the smallest head, first index wins ties
  logic             multi_r, best_more1_r;
  logic [VAL_W-1:0] best_val_r;
  logic             take;

  assign take = s1_valid_r && (!found_r || ($signed(rdata_r) < $signed(best_val_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      multi_r <= 1'b0;
    end else if (cmd.start_pop) begin
      found_r <= 1'b0;
      multi_r <= 1'b0;
    end else if (s1_valid_r) begin
      found_r <= 1'b1;
      if (found_r) begin
        multi_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_val_r   <= rdata_r;
      best_idx_r   <= s1_idx_r;
      best_pos_r   <= s1_pos_r;
      best_more1_r <= s1_more1_r;
    end
  end

  // Output register
  logic             out_valid_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_empty_r, out_last_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_val_r   <= found_r ? best_val_r : '0;
      out_empty_r <= !found_r;
      out_last_r  <= found_r && !(multi_r || best_more1_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_val_r;
  assign out_empty_res    = out_empty_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ----- src/k_way_sorted_merge_core.sv -----
// Top level of the k-way sorted merge core: controller plus datapath.
// Depends on kwm_pkg, kwm_ctrl and kwm_datapath.
//
//  channel | direction | fields (lowest bit first)
//  --------+-----------+-------------------------------------------------
//  in_     | sink      | tuser: kind[1:0]; tdata: list_index[2:0], value[34:3]
//  out_    | source    | tdata: merged_value; tuser: empty_res; tlast: last
//  cfg_    | write     | wr_data: lists_in_use[3:0]
//
// Append, clear and reserved transactions finish when accepted; the input stays open.
// A pop runs as: the accept cycle, one head read per active list through the
// element memory's single read port, a compare of the last head, then a finish
// step that writes the result and advances the winning list.
// A pop waits in its last cycle while the output register is still full.
// Reset is synchronous; lengths and read pointers clear at once, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module k_way_sorted_merge_core
  import kwm_pkg::*;
#(
  parameter int LIST_COUNT = 8,
  parameter int LIST_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // list_index[2:0], value[34:3], zero pad
  input  wire logic [KIND_W-1:0]     in_tuser,   // kind[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // merged_value[31:0]
  output logic                       out_tuser,  // empty_res
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_W-1:0]      cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  kwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kwm_datapath #(
    .LIST_COUNT (LIST_COUNT),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_list_index    (in_tdata[LIDX_W-1:0]),
    .in_value         (in_tdata[LIDX_W +: VAL_W]),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_merged_value (out_tdata),
    .out_empty_res    (out_tuser),
    .out_last         (out_tlast)
  );

endmodule

`default_nettype wire

// ----- src/kwm_checker.sv -----
// Port-level checker for the k-way sorted merge core, bound to the top level.
// Depends on kwm_pkg and k_way_sorted_merge_core.
`timescale 1ns / 1ps
`default_nettype none

module kwm_checker
  import kwm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [KIND_W-1:0]     in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  out_tlast
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // An empty pop returns zero and is never the final element
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == '0) && !out_tlast)
    else $error("empty result carries data or last");

  // A pop transaction keeps the input closed on the following cycle
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (kind_t'(in_tuser) == KIND_POP) |=> !in_tready)
    else $error("input open during a pop");

  // Non-pop transactions never create a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tvalid && in_tready && (kind_t'(in_tuser) != KIND_POP)
      |=> !out_tvalid)
    else $error("result without a pop");

  // Out of reset the block takes transactions
  a_reset_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_tready && !out_tvalid)
    else $error("not ready after reset");

endmodule

bind k_way_sorted_merge_core kwm_checker u_kwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
